// ===== src/satg_pkg.sv =====
// Shared types for the stereo AM tone generator: configuration record,
// datapath operation codes and the controller command word.
// No dependencies.
package satg_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CARRIER_INC_L = 3'd0;
    localparam logic [2:0] REG_CARRIER_INC_R = 3'd1;
    localparam logic [2:0] REG_LFO_INC_L     = 3'd2;
    localparam logic [2:0] REG_LFO_INC_R     = 3'd3;
    localparam logic [2:0] REG_DEPTH_L       = 3'd4;
    localparam logic [2:0] REG_DEPTH_R       = 3'd5;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd6;
    localparam logic [2:0] REG_LFO_START     = 3'd7;

    typedef struct packed {
        logic [31:0] carrier_inc_l;
        logic [31:0] carrier_inc_r;
        logic [31:0] lfo_inc_l;
        logic [31:0] lfo_inc_r;
        logic [16:0] depth_l;
        logic [16:0] depth_r;
        logic [16:0] amplitude;
        logic [31:0] lfo_start;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RD_CAR,
        OP_RD_LFO,
        OP_MUL_D,
        OP_MUL_C,
        OP_MUL_A,
        OP_ROUND,
        OP_FINISH
    } t_op;

    typedef struct packed {
        logic accept;
        t_op  op;
        logic chan;
    } t_cmd;

endpackage

// ===== src/satg_regs.sv =====
// Configuration register file of the stereo AM tone generator.
// Depends on satg_pkg for the register indexes and the t_cfg record.
module satg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output satg_pkg::t_cfg      o_cfg
);
    import satg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_inc_l <= 32'd17886749;
            r_cfg.carrier_inc_r <= 32'd17904645;
            r_cfg.lfo_inc_l     <= 32'd357914;
            r_cfg.lfo_inc_r     <= 32'd357914;
            r_cfg.depth_l       <= 17'd52429;
            r_cfg.depth_r       <= 17'd52429;
            r_cfg.amplitude     <= 17'd16384;
            r_cfg.lfo_start     <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CARRIER_INC_L: r_cfg.carrier_inc_l <= i_cfg_data;
                REG_CARRIER_INC_R: r_cfg.carrier_inc_r <= i_cfg_data;
                REG_LFO_INC_L:     r_cfg.lfo_inc_l     <= i_cfg_data;
                REG_LFO_INC_R:     r_cfg.lfo_inc_r     <= i_cfg_data;
                REG_DEPTH_L:       r_cfg.depth_l       <= i_cfg_data[16:0];
                REG_DEPTH_R:       r_cfg.depth_r       <= i_cfg_data[16:0];
                REG_AMPLITUDE:     r_cfg.amplitude     <= i_cfg_data[16:0];
                REG_LFO_START:     r_cfg.lfo_start     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/satg_ctrl.sv =====
// Sequencer of the stereo AM tone generator: walks both channels through
// the rom reads and the shared multiplier, owns the handshakes.
// Depends on satg_pkg for the command word.
module satg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output satg_pkg::t_cmd      o_cmd
);
    import satg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD_CAR = 8'b0000_0010,
        S_RD_LFO = 8'b0000_0100,
        S_MUL_D  = 8'b0000_1000,
        S_MUL_C  = 8'b0001_0000,
        S_MUL_A  = 8'b0010_0000,
        S_ROUND  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_chan, n_chan;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state    = r_state;
        n_chan     = r_chan;
        cmd.accept = 1'b0;
        cmd.op     = OP_NONE;
        cmd.chan   = r_chan;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_chan     = 1'b0;
                    n_state    = S_RD_CAR;
                end
            end
            S_RD_CAR: begin
                cmd.op  = OP_RD_CAR;
                n_state = S_RD_LFO;
            end
            S_RD_LFO: begin
                cmd.op  = OP_RD_LFO;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.op  = OP_MUL_D;
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                cmd.op  = OP_MUL_C;
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                cmd.op  = OP_MUL_A;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                cmd.op = OP_ROUND;
                if (!r_chan) begin
                    n_chan  = 1'b1;
                    n_state = S_RD_CAR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    cmd.op  = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.op == OP_FINISH) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== src/satg_dp.sv =====
// Datapath of the stereo AM tone generator: phase accumulators, sine rom,
// shared multiplier, rounding and saturation, output sample registers.
// Depends on satg_pkg for t_cfg, t_cmd and the operation codes.
module satg_dp #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  satg_pkg::t_cmd                i_cmd,
    input  satg_pkg::t_cfg                i_cfg,
    input  logic                          i_restart,
    output logic signed [SAMPLE_BITS-1:0] o_sample_left,
    output logic signed [SAMPLE_BITS-1:0] o_sample_right
);
    import satg_pkg::*;

    localparam int QB        = SINE_ADDR_BITS - 2;
    localparam int QSIZE     = 1 << QB;
    localparam int ROM_DEPTH = QSIZE + 1;
    localparam int SH        = 47 - SAMPLE_BITS;
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam logic [SAMPLE_BITS-1:0] NEG_LIMIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] POS_LIMIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef logic [14:0] t_rom [ROM_DEPTH];

    // shift-subtract quotient for the table build, operands never negative
    function automatic longint div_trunc(longint num, longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // quarter-wave entry by a fixed Q30 Taylor series, round half up
    function automatic logic [14:0] sine_entry(int k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        x    = (PI_HALF_Q30 * longint'(k)) >>> QB;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            term = div_trunc((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return v[14:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    function automatic logic [16:0] sat_q16(logic [16:0] v);
        return v[16] ? 17'h10000 : v;
    endfunction

    logic [PHASE_BITS-1:0]  r_cphase [2];
    logic [PHASE_BITS-1:0]  r_lphase [2];
    logic [14:0]            r_rom_q;
    logic                   r_rom_neg;
    logic [14:0]            r_cmag;
    logic                   r_cneg;
    logic [47:0]            r_prod;
    logic [SAMPLE_BITS-1:0] r_res [2];
    logic [SAMPLE_BITS-1:0] r_out_l;
    logic [SAMPLE_BITS-1:0] r_out_r;

    logic [PHASE_BITS-1:0]     rd_phase;
    logic [SINE_ADDR_BITS-1:0] rd_addr;
    logic [QB:0]               rd_idx;
    logic [16:0]               lfo_diff;
    logic [16:0]               depth_sat;
    logic [16:0]               amp_sat;
    logic [33:0]               depth_sum;
    logic [16:0]               m_val;
    logic [30:0]               mul_a;
    logic [16:0]               mul_b;
    logic [46:0]               rnd_sum;
    logic [SAMPLE_BITS-1:0]    rnd_mag;
    logic [SAMPLE_BITS-1:0]    sat_val;

    // rom address from the top phase bits, mirrored in odd quadrants
    always_comb begin
        rd_phase = (i_cmd.op == OP_RD_LFO) ? r_lphase[i_cmd.chan] : r_cphase[i_cmd.chan];
        rd_addr  = rd_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
        if (rd_addr[QB]) begin
            rd_idx = (QB+1)'(QSIZE) - {1'b0, rd_addr[QB-1:0]};
        end else begin
            rd_idx = {1'b0, rd_addr[QB-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RD_CAR || i_cmd.op == OP_RD_LFO) begin
            r_rom_q   <= SINE_ROM[rd_idx];
            r_rom_neg <= rd_addr[QB+1];
        end
        if (i_cmd.op == OP_RD_LFO) begin
            r_cmag <= r_rom_q;
            r_cneg <= r_rom_neg;
        end
    end

    always_comb begin
        depth_sat = sat_q16(i_cmd.chan ? i_cfg.depth_r : i_cfg.depth_l);
        amp_sat   = sat_q16(i_cfg.amplitude);
        lfo_diff  = r_rom_neg ? (17'd32768 + {2'b00, r_rom_q}) : (17'd32768 - {2'b00, r_rom_q});
        depth_sum = {1'b0, r_prod[32:0]} + 34'd65536;
        m_val     = 17'd32768 - depth_sum[33:17];
        unique case (i_cmd.op)
            OP_MUL_D: begin
                mul_a = 31'(lfo_diff);
                mul_b = depth_sat;
            end
            OP_MUL_C: begin
                mul_a = 31'(r_cmag);
                mul_b = m_val;
            end
            OP_MUL_A: begin
                mul_a = r_prod[30:0];
                mul_b = amp_sat;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL_D || i_cmd.op == OP_MUL_C || i_cmd.op == OP_MUL_A) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // round half away from zero on the magnitude, then clamp
    always_comb begin
        rnd_sum = {1'b0, r_prod[45:0]} + (47'd1 << (SH - 1));
        rnd_mag = rnd_sum[46:SH];
        if (r_cneg) begin
            sat_val = (rnd_mag > NEG_LIMIT) ? NEG_LIMIT : (SAMPLE_BITS'(0) - rnd_mag);
        end else begin
            sat_val = (rnd_mag > POS_LIMIT) ? POS_LIMIT : rnd_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ROUND) begin
            r_res[i_cmd.chan] <= sat_val;
        end
        if (i_cmd.op == OP_FINISH) begin
            r_out_l <= r_res[0];
            r_out_r <= r_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cphase[0] <= '0;
            r_cphase[1] <= '0;
            r_lphase[0] <= '0;
            r_lphase[1] <= '0;
        end else if (i_cmd.accept && i_restart) begin
            r_cphase[0] <= '0;
            r_cphase[1] <= '0;
            r_lphase[0] <= PHASE_BITS'(i_cfg.lfo_start[15:0]) << (PHASE_BITS - 16);
            r_lphase[1] <= PHASE_BITS'(i_cfg.lfo_start[31:16]) << (PHASE_BITS - 16);
        end else if (i_cmd.op == OP_FINISH) begin
            r_cphase[0] <= r_cphase[0] + PHASE_BITS'(i_cfg.carrier_inc_l);
            r_cphase[1] <= r_cphase[1] + PHASE_BITS'(i_cfg.carrier_inc_r);
            r_lphase[0] <= r_lphase[0] + PHASE_BITS'(i_cfg.lfo_inc_l);
            r_lphase[1] <= r_lphase[1] + PHASE_BITS'(i_cfg.lfo_inc_r);
        end
    end

    assign o_sample_left  = r_out_l;
    assign o_sample_right = r_out_r;

endmodule

// ===== src/stereo_am_tone_generator.sv =====
// Stereo amplitude-modulated sine oscillator, top level.
// Joins the configuration registers, the sequencer and the datapath.
//
// Input channel: i_in_valid / o_in_stall with the i_restart bit; one item
// asks for one stereo sample pair. A set restart bit clears both carrier
// phases and loads the LFO phases from the start-phase register first.
// Output channel: o_out_valid / i_out_stall with o_sample_left and
// o_sample_right, signed and saturated.
// From acceptance to a valid result, both channels run one after the
// other through two registered sine rom reads and three products on the
// single shared multiplier; then the output register is loaded. A new
// item is taken only after that, so the computations never overlap.
// While a result waits in the output register the next item is accepted
// and computed; it stays in the final state until the receiver takes the
// waiting pair. Reset restores the register defaults, zeroes all phases and
// empties the output register. Configuration writes take effect at once;
// the start phases only at the next restart.
module stereo_am_tone_generator #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_left,
    output logic signed [SAMPLE_BITS-1:0] o_sample_right,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);
    import satg_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    satg_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    satg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    satg_dp #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_restart      (i_restart),
        .o_sample_left  (o_sample_left),
        .o_sample_right (o_sample_right)
    );

endmodule

// ===== src/satg_checker.sv =====
// Port-level checks for the stereo AM tone generator, bound to the top.
// Depends only on the top level's ports.
module satg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic signed [SAMPLE_BITS-1:0] o_sample_left,
    input logic signed [SAMPLE_BITS-1:0] o_sample_right
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a held result keeps its samples
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sample_left) && $stable(o_sample_right))
        else $error("stalled result changed");

    // an accepted item keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // a new result only comes out of a busy block
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a computation");

endmodule

bind stereo_am_tone_generator satg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_satg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sample_left  (o_sample_left),
    .o_sample_right (o_sample_right)
);

// ===== dv/stereo_am_tone_generator_tb.sv =====
// Self-checking testbench for stereo_am_tone_generator: restart items in, stereo sample
// pairs out, each pair compared with a local oscillator and modulator prediction.
// Depends on satg_pkg (register indexes) and the block itself.
module stereo_am_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import satg_pkg::*;

    localparam int QUARTER    = 256;    // entries per quarter wave, less the end point
    localparam int IDLE_LIMIT = 1000;   // cycles with no handshake before giving up

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
    } t_stereo_pair;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_restart   = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_idx   = REG_CARRIER_INC_L;
    logic [31:0] i_cfg_data  = 32'h0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic signed [15:0] o_sample_left;
    logic signed [15:0] o_sample_right;

    stereo_am_tone_generator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_left  (o_sample_left),
        .o_sample_right (o_sample_right),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the registers and the four phase accumulators
    logic [31:0] car_inc_l, car_inc_r, lfo_inc_l, lfo_inc_r, lfo_start;
    logic [16:0] depth_l, depth_r, gain;
    logic [31:0] car_ph_l, car_ph_r, lfo_ph_l, lfo_ph_r;
    int          sine_q15 [0:QUARTER];

    logic         pending_restarts [$];
    t_stereo_pair expected_pairs [$];

    int unsigned in_gap_max   = 16;
    int unsigned out_wait_max = 16;
    int unsigned send_wait    = 0;
    int unsigned out_hold     = 0;
    int unsigned feed_gap;
    int unsigned hold_draw;
    int          mismatches   = 0;
    int          pairs_seen   = 0;
    int          restarts     = 0;
    int          settings     = 0;
    int          quiet_cycles = 0;

    // quarter-wave table from a fixed-point Taylor series, Q30 inside
    function automatic void build_sine_table();
        longint x, x2, term, acc, v;
        int k, n;
        for (k = 0; k <= QUARTER; k++) begin
            x = (longint'(1686629713) * k) >>> 8;
            x2 = (x * x) >>> 30;
            term = x;
            acc = x;
            for (n = 1; n <= 8; n++) begin
                term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) acc -= term;
                else acc += term;
            end
            if (acc < 0) acc = 0;
            v = (acc * 32767 + (longint'(1) << 29)) >>> 30;
            if (v > 32767) v = 32767;
            sine_q15[k] = int'(v);
        end
    endfunction

    function automatic longint sine_at(logic [31:0] phase);
        logic [1:0] quad;
        int         idx;
        longint     v;
        quad = phase[31:30];
        idx = int'(phase[29:22]);
        v = quad[0] ? sine_q15[QUARTER - idx] : sine_q15[idx];
        return quad[1] ? -v : v;
    endfunction

    function automatic logic [15:0] am_sample(logic [31:0] car_ph, logic [31:0] lfo_ph,
                                              logic [16:0] depth);
        longint c, lfo, d, a, t, m, mag, r;
        c = sine_at(car_ph);
        lfo = sine_at(lfo_ph);
        d = (depth > 17'd65536) ? 65536 : longint'(depth);
        a = (gain > 17'd65536) ? 65536 : longint'(gain);
        t = (d * (32768 - lfo) + 65536) >>> 17;
        m = 32768 - t;
        mag = (c < 0 ? -c : c) * m * a;
        // Q46 down to Q15, rounding the magnitude half up
        r = (mag + (longint'(1) << 30)) >>> 31;
        if (c < 0) begin
            if (r > 32768) r = 32768;
            r = -r;
        end else if (r > 32767) begin
            r = 32767;
        end
        return r[15:0];
    endfunction

    function automatic void reload_phases();
        car_ph_l = 32'h0;
        car_ph_r = 32'h0;
        lfo_ph_l = {lfo_start[15:0], 16'h0};
        lfo_ph_r = {lfo_start[31:16], 16'h0};
    endfunction

    function automatic t_stereo_pair advance_tone(logic restart);
        t_stereo_pair pair;
        if (restart) reload_phases();
        pair.left = am_sample(car_ph_l, lfo_ph_l, depth_l);
        pair.right = am_sample(car_ph_r, lfo_ph_r, depth_r);
        car_ph_l += car_inc_l;
        car_ph_r += car_inc_r;
        lfo_ph_l += lfo_inc_l;
        lfo_ph_r += lfo_inc_r;
        return pair;
    endfunction

    function automatic logic [31:0] random_setting(int idx);
        if (idx == REG_DEPTH_L || idx == REG_DEPTH_R || idx == REG_AMPLITUDE) begin
            case ($urandom_range(0, 7))
                0: return 32'd0;
                1: return 32'd65536;
                2: return $urandom_range(65537, 131071);
                default: return $urandom_range(0, 65536);
            endcase
        end
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // all eight registers, back to back, with the block idle
    task automatic apply_settings(input logic [31:0] vals [8]);
        int i;
        for (i = 0; i < 8; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= vals[i];
            case (3'(i))
                REG_CARRIER_INC_L: car_inc_l = vals[i];
                REG_CARRIER_INC_R: car_inc_r = vals[i];
                REG_LFO_INC_L:     lfo_inc_l = vals[i];
                REG_LFO_INC_R:     lfo_inc_r = vals[i];
                REG_DEPTH_L:       depth_l = vals[i][16:0];
                REG_DEPTH_R:       depth_r = vals[i][16:0];
                REG_AMPLITUDE:     gain = vals[i][16:0];
                REG_LFO_START:     lfo_start = vals[i];
                default: ;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
        @(negedge i_clk);
    endtask

    task automatic queue_pattern(input logic [31:0] pattern, input int count);
        int i;
        for (i = 0; i < count; i++) pending_restarts.push_back(pattern[i]);
    endtask

    // every item gives a pair, so an empty expectation queue means the block is idle
    task automatic settle();
        while (pending_restarts.size() != 0 || expected_pairs.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            expected_pairs.push_back(advance_tone(i_restart));
            if (i_restart) restarts++;
            feed_gap = $urandom_range(0, in_gap_max);
            if (feed_gap == 0 && pending_restarts.size() != 0) begin
                i_restart <= pending_restarts.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                send_wait <= feed_gap;
            end
        end else if (!i_in_valid) begin
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_restarts.size() != 0) begin
                i_in_valid <= 1'b1;
                i_restart <= pending_restarts.pop_front();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_hold <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (expected_pairs.size() == 0) begin
                $display("%0t: sample pair with none expected, left %0d right %0d",
                         $time, o_sample_left, o_sample_right);
                mismatches++;
            end else begin
                t_stereo_pair want;
                want = expected_pairs.pop_front();
                if (o_sample_left !== want.left) begin
                    $display("%0t: sample_left expected %0d actual %0d",
                             $time, $signed(want.left), o_sample_left);
                    mismatches++;
                end
                if (o_sample_right !== want.right) begin
                    $display("%0t: sample_right expected %0d actual %0d",
                             $time, $signed(want.right), o_sample_right);
                    mismatches++;
                end
            end
            pairs_seen++;
            hold_draw = $urandom_range(0, out_wait_max);
            out_hold <= hold_draw;
            i_out_stall <= (hold_draw != 0);
        end else if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            if (out_hold == 1) i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] vals [8];
        int p, n;
        build_sine_table();
        car_inc_l = 32'd17886749;
        car_inc_r = 32'd17904645;
        lfo_inc_l = 32'd357914;
        lfo_inc_r = 32'd357914;
        depth_l = 17'd52429;
        depth_r = 17'd52429;
        gain = 17'd16384;
        lfo_start = 32'h0;
        reload_phases();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values, restarts alone and in a row
        queue_pattern(32'hC8, 9);
        settle();

        // wrapping increments, full and over-range depth, unity gain;
        // the new start phases only show after the restart
        vals = '{32'hFFFF_FFFF, 32'h0, 32'h4000_0000, 32'hFFFF_FFFF,
                 32'd65536, 32'd131071, 32'd65536, 32'hC000_4000};
        apply_settings(vals);
        queue_pattern(32'h4, 7);
        settle();

        // carrier peaks with no modulation, over-range gain
        vals = '{32'h4000_0000, 32'hC000_0000, 32'h1234_5678, 32'h4000_0000,
                 32'd0, 32'd0, 32'd131071, 32'h0000_FFFF};
        apply_settings(vals);
        queue_pattern(32'h1, 5);
        settle();

        // silence
        vals = '{32'h4000_0000, 32'h4000_0000, 32'h2000_0000, 32'h8000_0000,
                 32'd65537, 32'd65535, 32'd0, 32'hFFFF_FFFF};
        apply_settings(vals);
        queue_pattern(32'h1, 3);
        settle();

        for (p = 0; p < 8; p++) begin
            for (n = 0; n < 8; n++) vals[n] = random_setting(n);
            apply_settings(vals);
            in_gap_max = (p % 4 == 1 || p % 4 == 2) ? 0 : 16;
            out_wait_max = (p % 4 == 1 || p % 4 == 3) ? 0 : 16;
            for (n = 0; n < 85; n++) pending_restarts.push_back($urandom_range(0, 11) == 0);
            settle();
        end

        $display("%0d sample pairs checked across %0d register settings, %0d of them restarts",
                 pairs_seen, settings, restarts);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
